### rtl/iso_ts_pkg.sv
// ----------------------------------------------------------------------------
// iso_ts_pkg: shared types, constants and tables
// Status codes, the record passed from the character scanner to the
// calendar back end, and small constant tables used by both sides.
// ----------------------------------------------------------------------------
package iso_ts_pkg;

   // maximum number of characters scanned per string
   localparam int unsigned MAX_LEN = 31;
   localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);

   // record queue depth, power of two
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OVERFLOW = 3'd1;
   localparam logic [2:0] ST_FORMAT   = 3'd2;
   localparam logic [2:0] ST_VALUE    = 3'd3;
   localparam logic [2:0] ST_TIME     = 3'd4;

   // separator positions
   localparam logic [2:0] SEP_YEAR   = 3'd0;
   localparam logic [2:0] SEP_MONTH  = 3'd1;
   localparam logic [2:0] SEP_DAY    = 3'd2;
   localparam logic [2:0] SEP_HOUR   = 3'd3;
   localparam logic [2:0] SEP_MINUTE = 3'd4;
   localparam logic [2:0] SEP_SECOND = 3'd5;
   localparam logic [2:0] SEP_FRAC   = 3'd6;
   localparam logic [2:0] SEP_COUNT  = 3'd7;

   // one parsed string, handed from the scanner to the back end
   typedef struct packed {
      logic [2:0]  err;
      logic [31:0] year_offset;   // years since 1900
      logic [3:0]  month;         // 0..11
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] frac_raw;      // fraction digits as written
      logic [3:0]  frac_scale;    // power of ten that scales it to ns
   } rec_type;

   function automatic logic [7:0] sep_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         SEP_YEAR:   ch = 8'h2D;  // '-'
         SEP_MONTH:  ch = 8'h2D;  // '-'
         SEP_DAY:    ch = 8'h54;  // 'T'
         SEP_HOUR:   ch = 8'h3A;  // ':'
         SEP_MINUTE: ch = 8'h3A;  // ':'
         SEP_SECOND: ch = 8'h2E;  // '.'
         SEP_FRAC:   ch = 8'h5A;  // 'Z'
         default:    ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [26:0] pow10(input logic [3:0] idx);
      logic [26:0] p;
      unique case (idx)
         4'd0:    p = 27'd1;
         4'd1:    p = 27'd10;
         4'd2:    p = 27'd100;
         4'd3:    p = 27'd1000;
         4'd4:    p = 27'd10000;
         4'd5:    p = 27'd100000;
         4'd6:    p = 27'd1000000;
         4'd7:    p = 27'd10000000;
         4'd8:    p = 27'd100000000;
         default: p = 27'd1;
      endcase
      return p;
   endfunction

   // day of the March-based year on which each month starts
   function automatic logic [8:0] month_doy(input logic [3:0] m0);
      logic [8:0] d;
      unique case (m0)
         4'd0:    d = 9'd306;
         4'd1:    d = 9'd337;
         4'd2:    d = 9'd0;
         4'd3:    d = 9'd31;
         4'd4:    d = 9'd61;
         4'd5:    d = 9'd92;
         4'd6:    d = 9'd122;
         4'd7:    d = 9'd153;
         4'd8:    d = 9'd184;
         4'd9:    d = 9'd214;
         4'd10:   d = 9'd245;
         4'd11:   d = 9'd275;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

### rtl/iso8601_text_to_timestamp.sv
// ----------------------------------------------------------------------------
// iso8601_text_to_timestamp: ISO 8601 UTC stamp to nanosecond time
// Scans YYYY-MM-DDTHH:MM:SS.fffZ one character per transfer and returns
// status plus nanoseconds since 1970 for each string.
// ----------------------------------------------------------------------------
// The input stream carries one character per transfer, and tlast marks the
// final character of a string. The scanner takes one character every cycle
// as long as its record queue has room; each string yields one result on the
// output stream once its last character is taken. Digits build a 64-bit
// value, separators must come in the order - - T : : . Z, and each field is
// range-checked as its separator closes it; a NUL byte or 31 characters end
// the scan, and the first error found is the one reported. Fields that a
// short string never closes take their defaults (year 1900, January, day 0,
// midnight), with day 0 and days past the month end rolling over. The
// calendar back end works on one record at a time and takes each string
// from the record at the queue head to the result in the output register
// through its chain of registered multiply steps (era division, day count,
// seconds, nanoseconds); strings that end in an error skip those steps. A
// two-entry queue lets the scanner keep taking characters while the back
// end is busy, so strings of 9 or more characters stream through at one
// character per cycle while the output stream takes results. Status codes:
// 0 success, 1 overflow, 2 invalid format, 3 invalid value, 4 invalid time
// (exactly one second before the epoch); time is zero whenever status is
// not zero, and negative times wrap modulo 2^64.
module iso8601_text_to_timestamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] time_ns
   output logic [2:0]  rsp_tuser     // [2:0] status
);
   import iso_ts_pkg::*;

   logic    q_full;
   logic    push;
   rec_type push_rec;
   logic    pop;
   logic    head_valid;
   rec_type head_rec;

   // scanner: accept characters, classify and range-check fields
   iso_ts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   // decouple scanner and back end
   iso_ts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .full       (q_full)
   );

   // calendar conversion and output register
   iso_ts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_TIME))
      else $error("result status outside defined codes");

   // a failed string never carries a time
   a_err_zero_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == 64'd0))
      else $error("nonzero time with error status");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

### rtl/iso_ts_front.sv
// ----------------------------------------------------------------------------
// iso_ts_front: character scanner
// Accepts one character per transfer, builds decimal values, checks the
// separator order and field ranges, and pushes one record per string.
// ----------------------------------------------------------------------------
module iso_ts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 q_full,
   output logic                 push,
   output iso_ts_pkg::rec_type  push_rec
);
   import iso_ts_pkg::*;

   localparam logic [63:0] SAT_LIMIT = 64'd1844674407370955161;  // (2^64-1)/10
   localparam logic [63:0] YEAR_MAX  = 64'd2147485617;           // 1970 + 2^31-1

   logic [63:0]      acc_ff, acc_in;
   logic             sat_ff, sat_in;
   logic [2:0]       sep_ff, sep_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             stop_ff, stop_in;
   rec_type          fld_ff, fld_in;

   logic             fire;
   logic             is_digit;
   logic [3:0]       digit;
   logic [63:0]      times10;
   logic [64:0]      sum;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign push       = fire && req_tlast;

   assign is_digit = (req_tdata >= 8'h30) && (req_tdata <= 8'h39);
   assign digit    = 4'(req_tdata - 8'h30);
   assign times10  = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
   assign sum      = {1'b0, times10} + {61'd0, digit};

   always_comb begin
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      sep_in   = sep_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      fld_in   = fld_ff;
      push_rec = fld_ff;
      if (fire) begin
         if (!stop_ff && fld_ff.err == ST_OK) begin
            if (req_tdata == 8'h00 || pos_ff >= POS_W'(MAX_LEN)) begin
               stop_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
               if (is_digit) begin
                  if (sat_ff || sum[64]) begin
                     fld_in.err = ST_OVERFLOW;
                  end else begin
                     acc_in = sum[63:0];
                     sat_in = sum[63:0] > SAT_LIMIT;
                     if (cnt_ff != 5'd31) begin
                        cnt_in = cnt_ff + 5'd1;
                     end
                  end
               end else if (sep_ff == SEP_COUNT || req_tdata != sep_char(sep_ff)) begin
                  fld_in.err = ST_FORMAT;
               end else begin
                  unique case (sep_ff)
                     SEP_YEAR: begin
                        if (acc_ff < 64'd1970 || acc_ff > YEAR_MAX) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.year_offset = 32'(acc_ff - 64'd1900);
                        end
                     end
                     SEP_MONTH: begin
                        if (acc_ff < 64'd1 || acc_ff > 64'd12) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.month = acc_ff[3:0] - 4'd1;
                        end
                     end
                     SEP_DAY: begin
                        if (acc_ff < 64'd1 || acc_ff > 64'd31) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.day = acc_ff[4:0];
                        end
                     end
                     SEP_HOUR: begin
                        if (acc_ff >= 64'd24) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.hour = acc_ff[4:0];
                        end
                     end
                     SEP_MINUTE: begin
                        if (acc_ff >= 64'd60) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.minute = acc_ff[5:0];
                        end
                     end
                     SEP_SECOND: begin
                        if (acc_ff >= 64'd60) begin
                           fld_in.err = ST_VALUE;
                        end else begin
                           fld_in.second = acc_ff[5:0];
                        end
                     end
                     default: begin
                        // fraction: value range first, then digit count
                        if (acc_ff >= 64'd1000000000) begin
                           fld_in.err = ST_VALUE;
                        end else if (cnt_ff == 5'd0 || cnt_ff > 5'd9) begin
                           fld_in.err = ST_FORMAT;
                        end else begin
                           fld_in.frac_raw   = acc_ff[29:0];
                           fld_in.frac_scale = 4'd9 - cnt_ff[3:0];
                        end
                     end
                  endcase
                  if (fld_in.err == ST_OK) begin
                     acc_in = 64'd0;
                     sat_in = 1'b0;
                     cnt_in = 5'd0;
                     sep_in = sep_ff + 3'd1;
                  end
               end
            end
         end
         push_rec = fld_in;
         // string done: return to the idle state
         if (req_tlast) begin
            acc_in  = 64'd0;
            sat_in  = 1'b0;
            sep_in  = 3'd0;
            cnt_in  = 5'd0;
            pos_in  = '0;
            stop_in = 1'b0;
            fld_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 64'd0;
         sat_ff  <= 1'b0;
         sep_ff  <= 3'd0;
         cnt_ff  <= 5'd0;
         pos_ff  <= '0;
         stop_ff <= 1'b0;
         fld_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         sat_ff  <= sat_in;
         sep_ff  <= sep_in;
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         stop_ff <= stop_in;
         fld_ff  <= fld_in;
      end
   end

endmodule

### rtl/iso_ts_queue.sv
// ----------------------------------------------------------------------------
// iso_ts_queue: record queue
// Small FIFO of parsed records between the scanner and the back end.
// ----------------------------------------------------------------------------
module iso_ts_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  iso_ts_pkg::rec_type  push_rec,
   input  logic                 pop,
   output logic                 head_valid,
   output iso_ts_pkg::rec_type  head_rec,
   output logic                 full
);
   import iso_ts_pkg::*;

   rec_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head_valid = cnt_ff != '0;
   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_rec   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_rec;
      end
   end

endmodule

### rtl/iso_ts_back.sv
// ----------------------------------------------------------------------------
// iso_ts_back: calendar back end
// Turns one parsed record into status and nanoseconds since 1970 through a
// short multi-step sequence, then holds the result in the output register.
// ----------------------------------------------------------------------------
module iso_ts_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  iso_ts_pkg::rec_type  head_rec,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser
);
   import iso_ts_pkg::*;

   localparam logic [27:0] DIV25_MUL  = 28'd171798691;  // floor(2^32/25)
   localparam logic [17:0] ERA_DAYS   = 18'd146097;
   localparam logic [63:0] EPOCH_BIAS = 64'd719469;     // epoch shift plus one
   localparam logic [16:0] SEC_DAY    = 17'd86400;
   localparam logic [29:0] NS_SEC     = 30'd1000000000;

   typedef enum logic [8:0] {
      B_IDLE = 9'b000000001,
      B_DIV  = 9'b000000010,
      B_CORR = 9'b000000100,
      B_DOE  = 9'b000001000,
      B_DAYS = 9'b000010000,
      B_SLO  = 9'b000100000,
      B_SECS = 9'b001000000,
      B_NLO  = 9'b010000000,
      B_OUT  = 9'b100000000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [27:0] x_ff;
   logic [3:0]  yylo_ff;
   logic [23:0] q_ff;
   logic [29:0] frac_ff;
   logic [23:0] era_ff;
   logic [8:0]  yoe_ff;
   logic [17:0] doe_ff;
   logic [41:0] eramul_ff;
   logic [63:0] days_ff;
   logic [48:0] plo_ff;
   logic [31:0] phi_ff;
   logic [16:0] hms_ff;
   logic [63:0] secs_ff;
   logic [61:0] nlo_ff;
   logic [31:0] nhi_ff;

   logic        out_ff;
   logic [63:0] time_ff;
   logic [2:0]  status_ff;

   logic [31:0] yy;
   logic [55:0] div_prod;
   logic [56:0] frac_prod;
   logic [5:0]  rem;
   logic [1:0]  cent;
   logic        out_free;

   assign out_free   = !out_ff || rsp_tready;
   assign pop        = (state_ff == B_OUT) && out_free;
   assign rsp_tvalid = out_ff;
   assign rsp_tdata  = time_ff;
   assign rsp_tuser  = status_ff;

   // March-based year: Jan and Feb count with the previous year
   assign yy        = head_rec.year_offset + 32'd1900 - {31'd0, head_rec.month < 4'd2};
   assign div_prod  = 56'(yy[31:4]) * 56'(DIV25_MUL);
   assign frac_prod = 57'(head_rec.frac_raw) * 57'(pow10(head_rec.frac_scale));
   assign rem       = x_ff[5:0] - 6'(q_ff * 24'd25);
   assign cent      = (yoe_ff >= 9'd300) ? 2'd3 :
                      (yoe_ff >= 9'd200) ? 2'd2 :
                      (yoe_ff >= 9'd100) ? 2'd1 : 2'd0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (head_valid) begin
            state_in = (head_rec.err == ST_OK) ? B_DIV : B_OUT;
         end
         B_DIV:  state_in = B_CORR;
         B_CORR: state_in = B_DOE;
         B_DOE:  state_in = B_DAYS;
         B_DAYS: state_in = B_SLO;
         B_SLO:  state_in = B_SECS;
         B_SECS: state_in = B_NLO;
         B_NLO:  state_in = B_OUT;
         B_OUT:  if (out_free) begin
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            out_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_ff <= 1'b0;
         end
      end
   end

   // datapath: each step's products and sums are registered before the next
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_DIV: begin
            x_ff    <= yy[31:4];
            yylo_ff <= yy[3:0];
            q_ff    <= div_prod[55:32];
            frac_ff <= frac_prod[29:0];
         end
         B_CORR: begin
            // estimate is low by at most one
            if (rem >= 6'd25) begin
               era_ff <= q_ff + 24'd1;
               yoe_ff <= {5'(rem - 6'd25), yylo_ff};
            end else begin
               era_ff <= q_ff;
               yoe_ff <= {rem[4:0], yylo_ff};
            end
         end
         B_DOE: begin
            doe_ff    <= 18'(yoe_ff * 18'd365) + 18'(yoe_ff[8:2]) - 18'(cent)
                         + 18'(month_doy(head_rec.month));
            eramul_ff <= era_ff * ERA_DAYS;
         end
         B_DAYS: begin
            days_ff <= 64'(eramul_ff) + 64'(doe_ff) + 64'(head_rec.day) - EPOCH_BIAS;
         end
         B_SLO: begin
            plo_ff <= 49'(days_ff[31:0]) * 49'(SEC_DAY);
            phi_ff <= 32'(days_ff[63:32] * 32'(SEC_DAY));
            hms_ff <= 17'(head_rec.hour * 17'd3600) + 17'(head_rec.minute * 17'd60)
                      + 17'(head_rec.second);
         end
         B_SECS: begin
            secs_ff <= 64'(plo_ff) + {phi_ff, 32'd0} + 64'(hms_ff);
         end
         B_NLO: begin
            nlo_ff <= 62'(secs_ff[31:0]) * 62'(NS_SEC);
            nhi_ff <= 32'(secs_ff[63:32] * 32'(NS_SEC));
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_rec.err != ST_OK) begin
            status_ff <= head_rec.err;
            time_ff   <= 64'd0;
         end else if (secs_ff == {64{1'b1}}) begin
            status_ff <= ST_TIME;
            time_ff   <= 64'd0;
         end else begin
            status_ff <= ST_OK;
            time_ff   <= 64'(nlo_ff) + {nhi_ff, 32'd0} + 64'(frac_ff);
         end
      end
   end

endmodule
